[rtl/aes_ctr_pkg.sv]
// Shared types, constants and AES functions for the counter-mode keystream block.
package aes_ctr_pkg;

	localparam int MaxBlocks = 64;
	localparam int NumRounds = 10;
	localparam int MaxBytes = MaxBlocks * 16;

	localparam logic [1:0] REG_KEY_LOW = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_NONCE = 2'd2;
	localparam logic [1:0] REG_INIT_CTR = 2'd3;

	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_RESET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_OUTPUT
	} ctrl_state_t;

	typedef struct packed {
		logic start_expand;
		logic step_expand;
		logic load_block;
		logic step_round;
		logic load_counter;
		logic advance_counter;
		logic [4:0] valid_bytes;
		logic last;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic expand_done;
		logic round_done;
	} dp_status_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		case (r)
			4'd0: return 8'h01;
			4'd1: return 8'h02;
			4'd2: return 8'h04;
			4'd3: return 8'h08;
			4'd4: return 8'h10;
			4'd5: return 8'h20;
			4'd6: return 8'h40;
			4'd7: return 8'h80;
			4'd8: return 8'h1b;
			4'd9: return 8'h36;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[rtl/aes_ctr_if.sv]
// Valid/ready channel interfaces for requests and keystream blocks.
interface aes_ctr_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [10:0] byte_count;
	modport source (output valid, opcode, byte_count, input ready);
	modport sink (input valid, opcode, byte_count, output ready);
endinterface

interface aes_ctr_blk_if;
	logic valid;
	logic ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic [4:0] valid_bytes;
	logic last;
	modport source (output valid, block_low, block_high, valid_bytes, last, input ready);
	modport sink (input valid, block_low, block_high, valid_bytes, last, output ready);
endinterface

[rtl/aes_ctr_datapath.sv]
// Key schedule, round unit, block counter and output register.
module aes_ctr_datapath
	import aes_ctr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic [63:0] key_low,
	input logic [63:0] key_high,
	input logic [63:0] nonce,
	input logic [63:0] initial_counter,
	input dp_cmd_t cmd,
	output dp_status_t status,
	output logic [127:0] out_data,
	output logic [4:0] out_valid_bytes,
	output logic out_last
);

	// round_key_q holds all 11 round keys; entry r is filled at expansion step r
	logic [127:0] round_key_q [NumRounds+1];
	logic [3:0] key_idx_q;
	logic [127:0] state_q;
	logic [3:0] round_q;
	logic [63:0] counter_q;
	logic [127:0] next_key;
	logic [127:0] round_out;
	logic [127:0] sub_shift;
	logic [127:0] mixed;
	logic [127:0] masked;

	// one key-schedule round from the previous round key
	always_comb begin
		logic [31:0] w3;
		logic [31:0] t;
		logic [127:0] prev;
		prev = round_key_q[key_idx_q - 4'd1];
		w3 = prev[127:96];
		t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]),
			sbox(w3[15:8]) ^ rcon(key_idx_q - 4'd1)};
		next_key[31:0] = prev[31:0] ^ t;
		next_key[63:32] = prev[63:32] ^ next_key[31:0];
		next_key[95:64] = prev[95:64] ^ next_key[63:32];
		next_key[127:96] = prev[127:96] ^ next_key[95:64];
	end

	// sub bytes, shift rows, then mix columns unless final round
	always_comb begin
		logic [7:0] a0, a1, a2, a3, all;
		for (int i = 0; i < 16; i++) begin
			sub_shift[8*i +: 8] =
				sbox(state_q[8*((i & 3) + 4*(((i >> 2) + (i & 3)) & 3)) +: 8]);
		end
		for (int c = 0; c < 4; c++) begin
			a0 = sub_shift[32*c +: 8];
			a1 = sub_shift[32*c+8 +: 8];
			a2 = sub_shift[32*c+16 +: 8];
			a3 = sub_shift[32*c+24 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			mixed[32*c +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			mixed[32*c+8 +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			mixed[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			mixed[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		round_out = ((round_q == 4'(NumRounds)) ? sub_shift : mixed) ^ round_key_q[round_q];
		// the final round goes straight into the output register
		for (int i = 0; i < 16; i++) begin
			masked[8*i +: 8] = (5'(i) < cmd.valid_bytes) ? round_out[8*i +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_expand) begin
			round_key_q[0] <= {key_high, key_low};
		end else if (cmd.step_expand) begin
			round_key_q[key_idx_q] <= next_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_idx_q <= 4'd1;
			round_q <= 4'd1;
			counter_q <= '0;
		end else begin
			if (cmd.start_expand) key_idx_q <= 4'd1;
			else if (cmd.step_expand) key_idx_q <= key_idx_q + 4'd1;
			if (cmd.load_block) round_q <= 4'd1;
			else if (cmd.step_round) round_q <= round_q + 4'd1;
			if (cmd.load_counter) counter_q <= initial_counter;
			else if (cmd.advance_counter) counter_q <= counter_q + 64'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_block) begin
			state_q <= {nonce, counter_q} ^ round_key_q[0];
		end else if (cmd.step_round) begin
			state_q <= round_out;
		end
		if (cmd.load_out) begin
			out_data <= masked;
			out_valid_bytes <= cmd.valid_bytes;
			out_last <= cmd.last;
		end
	end

	assign status.expand_done = (key_idx_q == 4'(NumRounds));
	assign status.round_done = (round_q == 4'(NumRounds));

endmodule

[rtl/aes_ctr_ctrl.sv]
// Request sequencer: key expansion, per-block rounds and output handshake.
module aes_ctr_ctrl
	import aes_ctr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	aes_ctr_req_if.sink req,
	input logic out_ready,
	output logic out_valid,
	input dp_status_t status,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic [10:0] remain_q;
	logic out_full_q;
	logic first_q;
	logic [10:0] req_bytes;
	logic block_done;

	assign req_bytes = (req.byte_count > 11'(MaxBytes)) ? 11'(MaxBytes) : req.byte_count;
	assign req.ready = (state_q == ST_IDLE) && !first_q;
	assign out_valid = out_full_q;
	assign block_done = (state_q == ST_ROUND) && status.round_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (first_q) state_d = ST_EXPAND;
				else if (req.valid && req.opcode == OP_RESET) state_d = ST_EXPAND;
				else if (req.valid && req_bytes != 11'd0) state_d = ST_ROUND;
			end
			ST_EXPAND: if (status.expand_done) state_d = ST_IDLE;
			ST_ROUND: if (status.round_done && (!out_full_q || out_ready)) begin
				state_d = (remain_q <= 11'd16) ? ST_IDLE : ST_OUTPUT;
			end
			ST_OUTPUT: state_d = ST_ROUND;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		logic go;
		go = req.valid && req.ready;
		cmd = '0;
		cmd.start_expand = (state_q == ST_IDLE) && (first_q || (go && req.opcode == OP_RESET));
		cmd.load_counter = cmd.start_expand;
		cmd.step_expand = (state_q == ST_EXPAND);
		cmd.load_block = ((state_q == ST_IDLE) && go && req.opcode == OP_GENERATE
			&& req_bytes != 11'd0) || (state_q == ST_OUTPUT);
		cmd.step_round = (state_q == ST_ROUND) && !status.round_done;
		cmd.load_out = block_done && (!out_full_q || out_ready);
		cmd.advance_counter = cmd.load_out;
		cmd.valid_bytes = (remain_q >= 11'd16) ? 5'd16 : 5'(remain_q);
		cmd.last = (remain_q <= 11'd16);
	end

	// step_expand on the final index writes round key 10 in the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			remain_q <= '0;
			out_full_q <= 1'b0;
			first_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cmd.start_expand) first_q <= 1'b0;
			if ((state_q == ST_IDLE) && req.valid && req.ready) remain_q <= req_bytes;
			else if (cmd.load_out) remain_q <= remain_q - 11'(cmd.valid_bytes);
			if (cmd.load_out) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("request taken while busy");
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(out_full_q && !out_ready) |-> !cmd.load_out) else $error("output overwritten");
	a_remain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (remain_q != 11'd0)) else $error("empty block run");
`endif

endmodule

[rtl/aes128_ctr_keystream_top.sv]
// AES-128 counter-mode keystream generator. A generate request of N bytes (saturated at
// 1024) yields ceil(N/16) blocks, one round per clock on a shared round unit, with each
// block's final round held while the output register is full and not taken. A reset
// request or power-up expands the key, one schedule round a cycle, and reloads the
// counter. Requests are taken only when idle. Key writes take effect only on the next
// reset request.
module aes128_ctr_keystream_top
	import aes_ctr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_wdata,
	aes_ctr_req_if.sink req,
	aes_ctr_blk_if.source blk
);

	logic [63:0] key_low_q, key_high_q, nonce_q, init_ctr_q;
	dp_cmd_t cmd;
	dp_status_t status;
	logic [127:0] out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			nonce_q <= '0;
			init_ctr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_LOW: key_low_q <= cfg_wdata;
				REG_KEY_HIGH: key_high_q <= cfg_wdata;
				REG_NONCE: nonce_q <= cfg_wdata;
				REG_INIT_CTR: init_ctr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	aes_ctr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(req), .out_ready(blk.ready),
		.out_valid(blk.valid), .status(status), .cmd(cmd)
	);

	aes_ctr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .key_low(key_low_q), .key_high(key_high_q),
		.nonce(nonce_q), .initial_counter(init_ctr_q), .cmd(cmd), .status(status),
		.out_data(out_data), .out_valid_bytes(blk.valid_bytes), .out_last(blk.last)
	);

	assign blk.block_low = out_data[63:0];
	assign blk.block_high = out_data[127:64];

endmodule
